/* rtl/core/wte_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// wte_pkg
// Shared types, constants and register codes of the wrapped timestamp extender.
// ----------------------------------------------------------------------------
package wte_pkg;

	localparam int CHANNELS_DEF     = 4;
	localparam int COUNTER_BITS_DEF = 32;

	localparam int CH_W     = 2;
	localparam int FAST_W   = 32;
	localparam int SLOW_W   = 32;
	localparam int MEAN_W   = 63;
	localparam int FPER_W   = 32;
	localparam int SPER_W   = 48;
	localparam int CSEL_W   = 3;
	localparam int NPER     = 4;
	localparam int WRAP_W   = 32;
	localparam int SUM_W    = 64;
	localparam int HITS_W   = 16;
	localparam int DVD_W    = 80;
	localparam int DVS_W    = 32;
	localparam int APB_AW   = 6;
	localparam int APB_DW   = 64;

	localparam logic [MEAN_W-1:0] MAX63 = '1;

	typedef enum logic [2:0] {
		REG_CHSEL  = 3'd0,
		REG_FPER_A = 3'd1,
		REG_FPER_B = 3'd2,
		REG_FPER_C = 3'd3,
		REG_FPER_D = 3'd4,
		REG_SPER   = 3'd5
	} wte_reg_t;

	typedef struct packed {
		logic [CSEL_W-1:0]            chsel;
		logic [NPER-1:0][FPER_W-1:0]  fast_period;
		logic [SPER_W-1:0]            slow_period;
	} wte_cfg_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_CHECK,
		ST_EMUL_LO,
		ST_EMUL_HI,
		ST_EDIV_GO,
		ST_EDIV_WAIT,
		ST_NCALC,
		ST_TMUL_LO,
		ST_TMUL_HI,
		ST_TACC,
		ST_MEAN_GO,
		ST_MEAN_WAIT,
		ST_OUT
	} wte_state_t;

endpackage
`default_nettype wire

/* rtl/core/wte_hit_if.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// wte_hit_if
// Hit channel: valid/ready handshake with one hit per beat.
// ----------------------------------------------------------------------------
interface wte_hit_if;
	logic                        valid;
	logic                        ready;
	logic [wte_pkg::CH_W-1:0]    channel;
	logic [wte_pkg::FAST_W-1:0]  fast_time;
	logic [wte_pkg::SLOW_W-1:0]  slow_count;
	logic                        last_hit;

	modport source (output valid, channel, fast_time, slow_count, last_hit, input ready);
	modport sink   (input valid, channel, fast_time, slow_count, last_hit, output ready);
endinterface
`default_nettype wire

/* rtl/core/wte_res_if.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// wte_res_if
// Result channel: valid/ready handshake with one event mean per beat.
// ----------------------------------------------------------------------------
interface wte_res_if;
	logic                        valid;
	logic                        ready;
	logic [wte_pkg::MEAN_W-1:0]  mean_time;
	logic                        time_valid;

	modport source (output valid, mean_time, time_valid, input ready);
	modport sink   (input valid, mean_time, time_valid, output ready);
endinterface
`default_nettype wire

/* rtl/core/wte_regs.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// wte_regs
// APB configuration registers: channel select, fast and slow periods.
// ----------------------------------------------------------------------------
module wte_regs (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         psel,
	input  wire logic                         penable,
	input  wire logic                         pwrite,
	input  wire logic [wte_pkg::APB_AW-1:0]   paddr,
	input  wire logic [wte_pkg::APB_DW-1:0]   pwdata,
	output logic      [wte_pkg::APB_DW-1:0]   prdata,
	output logic                              pready,
	output wte_pkg::wte_cfg_t                 cfg
);
	import wte_pkg::*;

	wte_cfg_t  cfg_q;
	wte_reg_t  idx;
	logic      wr;

	assign idx    = wte_reg_t'(paddr[APB_AW-1:3]);
	assign wr     = psel && penable && pwrite;
	assign pready = 1'b1;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.chsel       <= '1;
			cfg_q.fast_period <= {NPER{FPER_W'(65536)}};
			cfg_q.slow_period <= SPER_W'(65536000);
		end else if (wr) begin
			case (idx)
				REG_CHSEL:  cfg_q.chsel          <= pwdata[CSEL_W-1:0];
				REG_FPER_A: cfg_q.fast_period[0] <= pwdata[FPER_W-1:0];
				REG_FPER_B: cfg_q.fast_period[1] <= pwdata[FPER_W-1:0];
				REG_FPER_C: cfg_q.fast_period[2] <= pwdata[FPER_W-1:0];
				REG_FPER_D: cfg_q.fast_period[3] <= pwdata[FPER_W-1:0];
				REG_SPER:   cfg_q.slow_period    <= pwdata[SPER_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (idx)
			REG_CHSEL:  prdata = APB_DW'(cfg_q.chsel);
			REG_FPER_A: prdata = APB_DW'(cfg_q.fast_period[0]);
			REG_FPER_B: prdata = APB_DW'(cfg_q.fast_period[1]);
			REG_FPER_C: prdata = APB_DW'(cfg_q.fast_period[2]);
			REG_FPER_D: prdata = APB_DW'(cfg_q.fast_period[3]);
			REG_SPER:   prdata = APB_DW'(cfg_q.slow_period);
			default:    prdata = '0;
		endcase
	end
endmodule
`default_nettype wire

/* rtl/core/wte_div.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// wte_div
// Shared restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module wte_div (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        start,
	input  wire logic [wte_pkg::DVD_W-1:0]   dividend,
	input  wire logic [wte_pkg::DVS_W-1:0]   divisor,
	output logic                             busy,
	output logic                             done,
	output logic      [wte_pkg::DVD_W-1:0]   quotient
);
	import wte_pkg::*;

	localparam int CNT_W = $clog2(DVD_W + 1);

	logic [DVD_W-1:0] dvd_q;
	logic [DVS_W-1:0] dvs_q;
	logic [DVS_W-1:0] rem_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;
	logic [DVS_W:0]   trial;
	logic [DVS_W:0]   diff;
	logic             qbit;

	assign trial    = {rem_q, dvd_q[DVD_W-1]};
	assign diff     = trial - {1'b0, dvs_q};
	assign qbit     = (trial >= {1'b0, dvs_q});
	assign busy     = busy_q;
	assign done     = done_q;
	assign quotient = dvd_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(DVD_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			dvs_q <= divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			dvd_q <= {dvd_q[DVD_W-2:0], qbit};
			rem_q <= qbit ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
		end
	end
endmodule
`default_nettype wire

/* rtl/core/wrapped_timestamp_extender.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// wrapped_timestamp_extender
// Extends wrapping fast-counter hit times and gives the per-event mean.
// ----------------------------------------------------------------------------
//  port       dir    handshake              beat
//  hit        sink   valid/ready            channel, fast_time, slow_count, last_hit
//  res        source valid/ready            mean_time, time_valid (one per event)
//  apb        slave  psel/penable, pready=1 channel_select, periods
//
//  A skipped hit goes from check back to idle. A used hit goes through the tick
//  count, two multiply steps and the accumulate step, after two multiply steps,
//  a start state and a wait on the 80-step divide in the shared divider when slow
//  elapsed time adds wraps. A last hit then runs the mean divide through the same
//  unit when a hit was used, and waits out any stall on the result port.
//  Reset clears the history (first_count_q is gated); no clearing pass is needed.
//  hit.ready is high only while the sequencer is idle; a waiting result is held
//  in the output register while the next hit is already taken.
// ----------------------------------------------------------------------------
module wrapped_timestamp_extender #(
	parameter int CHANNELS     = wte_pkg::CHANNELS_DEF,
	parameter int COUNTER_BITS = wte_pkg::COUNTER_BITS_DEF
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	wte_hit_if.sink                          hit,
	wte_res_if.source                        res,
	input  wire logic                        psel,
	input  wire logic                        penable,
	input  wire logic                        pwrite,
	input  wire logic [wte_pkg::APB_AW-1:0]  paddr,
	input  wire logic [wte_pkg::APB_DW-1:0]  pwdata,
	output logic      [wte_pkg::APB_DW-1:0]  prdata,
	output logic                             pready
);
	import wte_pkg::*;

	localparam int CH_IW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
	localparam logic [FAST_W-1:0] FAST_MASK =
		(COUNTER_BITS >= FAST_W) ? {FAST_W{1'b1}} : FAST_W'((64'd1 << COUNTER_BITS) - 64'd1);

	wte_cfg_t   cfg;
	wte_state_t state_q, state_d;

	// captured hit
	logic [CH_W-1:0]   ch_q;
	logic [FAST_W-1:0] fast_q;
	logic [SLOW_W-1:0] slow_q;
	logic              last_q;

	// per-channel history
	logic [FAST_W-1:0] first_count_q [CHANNELS];
	logic [CHANNELS-1:0] first_seen_q;
	logic [FAST_W-1:0] prior_count_q [CHANNELS];

	logic [WRAP_W-1:0] wrap_q;
	logic [SLOW_W-1:0] prior_slow_q;
	logic [SUM_W-1:0]  sum_q;
	logic [HITS_W-1:0] hits_q;

	// working registers
	logic [FPER_W-1:0] per_q;
	logic [FAST_W-1:0] fc_q;
	logic [SLOW_W-1:0] delta_q;
	logic [63:0]       n_q;
	logic [63:0]       mul_q;
	logic [63:0]       acc_q;
	logic [MEAN_W-1:0] pend_mean_q;
	logic              pend_tv_q;

	// output register
	logic              out_valid_q;
	logic [MEAN_W-1:0] out_mean_q;
	logic              out_tv_q;

	logic [CH_IW-1:0]  ch_idx;
	logic              use_hit;
	logic [FPER_W-1:0] per_cur;
	logic              el_go;
	logic [31:0]       mul_a, mul_b;
	logic              div_start, div_busy, div_done;
	logic [DVD_W-1:0]  div_dvd, div_quo;
	logic [DVS_W-1:0]  div_dvs;
	logic [DVD_W-1:0]  eprod;
	logic [95:0]       base_wide;
	logic [63:0]       base;
	logic [63:0]       n_calc;
	logic [64:0]       n_add;
	logic [FAST_W-1:0] back;
	logic [64:0]       t_hi;
	logic [63:0]       t_val;
	logic [64:0]       sum_add;
	logic [WRAP_W-1:0] ewraps;
	logic [WRAP_W:0]   wrap_add;
	logic              out_load;

	wte_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	wte_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dvd),
		.divisor  (div_dvs),
		.busy     (div_busy),
		.done     (div_done),
		.quotient (div_quo)
	);

	assign ch_idx  = CH_IW'(ch_q);
	// negative channel select takes every channel
	assign use_hit = (int'(ch_q) < CHANNELS) &&
		(cfg.chsel[CSEL_W-1] || ({1'b0, ch_q} == cfg.chsel));
	assign per_cur = cfg.fast_period[ch_q];
	assign el_go   = (prior_slow_q != '0) && (slow_q >= prior_slow_q) && (per_cur != '0);

	assign hit.ready     = (state_q == ST_IDLE);
	assign res.valid     = out_valid_q;
	assign res.mean_time = out_mean_q;
	assign res.time_valid = out_tv_q;
	assign out_load      = (state_q == ST_OUT) && (!out_valid_q || res.ready);

	// shared multiplier operand select
	always_comb begin
		case (state_q)
			ST_EMUL_LO: begin
				mul_a = delta_q;
				mul_b = cfg.slow_period[31:0];
			end
			ST_EMUL_HI: begin
				mul_a = delta_q;
				mul_b = 32'(cfg.slow_period[SPER_W-1:32]);
			end
			ST_TMUL_LO: begin
				mul_a = n_q[31:0];
				mul_b = per_q;
			end
			ST_TMUL_HI: begin
				mul_a = n_q[63:32];
				mul_b = per_q;
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	// slow elapsed product, shifted down by the counter width
	assign eprod = DVD_W'(acc_q) + (DVD_W'(mul_q) << 32);

	always_comb begin
		div_start = 1'b0;
		div_dvd   = eprod >> COUNTER_BITS;
		div_dvs   = per_q;
		if (state_q == ST_EDIV_GO) begin
			div_start = 1'b1;
		end else if (state_q == ST_MEAN_GO && hits_q != '0) begin
			div_start = 1'b1;
			div_dvd   = DVD_W'(sum_q);
			div_dvs   = DVS_W'(hits_q);
		end
	end

	assign ewraps   = (div_quo[DVD_W-1:WRAP_W] != '0) ? '1 : div_quo[WRAP_W-1:0];
	assign wrap_add = {1'b0, wrap_q} + {1'b0, ewraps};

	// extended tick count
	assign base_wide = 96'(wrap_q) << COUNTER_BITS;
	assign base      = (base_wide[95:64] != '0) ? '1 : base_wide[63:0];
	assign n_add     = {1'b0, base} + 65'(fast_q - fc_q);
	assign back      = fc_q - fast_q;
	always_comb begin
		if (fast_q >= fc_q)
			n_calc = n_add[64] ? '1 : n_add[63:0];
		else if (base >= 64'(back))
			n_calc = base - 64'(back);
		else
			n_calc = '0;
	end

	assign t_hi    = {1'b0, mul_q} + 65'(acc_q[63:32]);
	assign t_val   = (t_hi[64:31] != '0) ? {1'b0, MAX63} : {1'b0, t_hi[30:0], acc_q[31:0]};
	assign sum_add = {1'b0, sum_q} + {1'b0, t_val};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_IDLE;
		else
			state_q <= state_d;
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE:      if (hit.valid) state_d = ST_CHECK;
			ST_CHECK: begin
				if (!use_hit)
					state_d = last_q ? ST_MEAN_GO : ST_IDLE;
				else
					state_d = el_go ? ST_EMUL_LO : ST_NCALC;
			end
			ST_EMUL_LO:   state_d = ST_EMUL_HI;
			ST_EMUL_HI:   state_d = ST_EDIV_GO;
			ST_EDIV_GO:   state_d = ST_EDIV_WAIT;
			ST_EDIV_WAIT: if (div_done) state_d = ST_NCALC;
			ST_NCALC:     state_d = ST_TMUL_LO;
			ST_TMUL_LO:   state_d = ST_TMUL_HI;
			ST_TMUL_HI:   state_d = ST_TACC;
			ST_TACC:      state_d = last_q ? ST_MEAN_GO : ST_IDLE;
			ST_MEAN_GO:   state_d = (hits_q == '0) ? ST_OUT : ST_MEAN_WAIT;
			ST_MEAN_WAIT: if (div_done) state_d = ST_OUT;
			ST_OUT:       if (out_load) state_d = ST_IDLE;
			default:      state_d = ST_IDLE;
		endcase
	end

	// history and accumulators
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			first_seen_q <= '0;
			wrap_q       <= '0;
			prior_slow_q <= '0;
			sum_q        <= '0;
			hits_q       <= '0;
			for (int i = 0; i < CHANNELS; i++) prior_count_q[i] <= '0;
		end else begin
			case (state_q)
				ST_CHECK: begin
					if (use_hit) begin
						first_seen_q[ch_idx]  <= 1'b1;
						prior_count_q[ch_idx] <= fast_q;
						prior_slow_q          <= slow_q;
						// counter went backwards: one more wrap
						if (prior_count_q[ch_idx] != '0 && fast_q < prior_count_q[ch_idx] &&
						    wrap_q != '1)
							wrap_q <= wrap_q + 1'b1;
					end
				end
				ST_EDIV_WAIT: begin
					if (div_done) wrap_q <= wrap_add[WRAP_W] ? '1 : wrap_add[WRAP_W-1:0];
				end
				ST_TACC: begin
					sum_q <= sum_add[SUM_W] ? '1 : sum_add[SUM_W-1:0];
					if (hits_q != '1) hits_q <= hits_q + 1'b1;
				end
				ST_OUT: begin
					if (out_load) begin
						sum_q  <= '0;
						hits_q <= '0;
					end
				end
				default: ;
			endcase
		end
	end

	// payload and working registers
	always_ff @(posedge clk) begin
		mul_q <= mul_a * mul_b;
		if (state_q == ST_EMUL_HI || state_q == ST_TMUL_HI) acc_q <= mul_q;
		if (state_q == ST_IDLE && hit.valid) begin
			ch_q   <= hit.channel;
			fast_q <= hit.fast_time & FAST_MASK;
			slow_q <= hit.slow_count;
			last_q <= hit.last_hit;
		end
		if (state_q == ST_CHECK) begin
			per_q   <= per_cur;
			delta_q <= slow_q - prior_slow_q;
			fc_q    <= first_seen_q[ch_idx] ? first_count_q[ch_idx] : fast_q;
			if (use_hit && !first_seen_q[ch_idx]) first_count_q[ch_idx] <= fast_q;
		end
		if (state_q == ST_NCALC) n_q <= n_calc;
		if (state_q == ST_MEAN_GO) begin
			pend_mean_q <= '0;
			pend_tv_q   <= 1'b0;
		end
		if (state_q == ST_MEAN_WAIT && div_done) begin
			pend_mean_q <= (div_quo[DVD_W-1:MEAN_W] != '0) ? MAX63 : div_quo[MEAN_W-1:0];
			pend_tv_q   <= 1'b1;
		end
		if (out_load) begin
			out_mean_q <= pend_mean_q;
			out_tv_q   <= pend_tv_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (out_load)
			out_valid_q <= 1'b1;
		else if (res.ready)
			out_valid_q <= 1'b0;
	end

	// never start the divider while it still works
	assert property (@(posedge clk) disable iff (!arst_n) div_start |-> !div_busy)
		else $error("divider restarted while busy");

	// an empty accumulator has no time in it
	assert property (@(posedge clk) disable iff (!arst_n) (hits_q == '0) |-> (sum_q == '0))
		else $error("time sum without used hits");

	// the wrap count never goes down
	assert property (@(posedge clk) disable iff (!arst_n) wrap_q >= $past(wrap_q))
		else $error("wrap count decreased");

	// an invalid mean is always zero
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !out_tv_q) |-> (out_mean_q == '0))
		else $error("nonzero mean without used hits");

endmodule
`default_nettype wire
